>>> hdl/nse_pkg.sv
// ----------------------------------------------------------------------------
// nse_pkg
// Shared types, constants and helpers for the named section extractor.
// ----------------------------------------------------------------------------
package nse_pkg;

  // Section header layout.
  localparam int unsigned HEADER_BYTES       = 512;
  localparam int unsigned NAME_COMPARE_BYTES = 31;
  localparam int unsigned NAME_FIELD_START   = 8;
  localparam int unsigned HPOS_W             = $clog2(HEADER_BYTES);

  // The wanted name is held as 31 bytes in four registers.
  localparam int unsigned NAME_REG_BYTES = 31;
  localparam int unsigned NAME_IDX_W     = $clog2(NAME_REG_BYTES);

  localparam logic [31:0] SECTION_MAGIC = 32'h5888_1688;
  localparam logic [31:0] SKIP_ALIGN    = 32'd16;

  // Stream widths.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_TUSER_W = 2;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam logic [CFG_INDEX_W-1:0] CFG_NAME_0_7   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NAME_8_15  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NAME_16_23 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_NAME_24_30 = 2'd3;

  typedef logic [NAME_REG_BYTES-1:0][7:0] name_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_COPY   = 2'd1,
    PH_SKIP   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_FOUND     = 2'd1,
    KIND_NOT_FOUND = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [31:0] size;
  } result_t;

  // All results caused by one input byte: one, or two when 'two' is set.
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } bundle_t;

  function automatic result_t mk_result(kind_t kind, logic [7:0] data_byte,
                                        logic [31:0] size);
    result_t r;
    r.kind      = kind;
    r.data_byte = data_byte;
    r.size      = size;
    return r;
  endfunction

endpackage

>>> hdl/nse_cfg.sv
// ----------------------------------------------------------------------------
// nse_cfg
// Register file for the wanted section name.
// ----------------------------------------------------------------------------
module nse_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [nse_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [nse_pkg::CFG_DATA_W-1:0]     wr_data,
  output nse_pkg::name_t                     name
);

  logic [63:0] name0_r, name1_r, name2_r;
  logic [55:0] name3_r;

  // Write one register per transaction; the top register keeps 7 bytes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name0_r <= '0;
      name1_r <= '0;
      name2_r <= '0;
      name3_r <= '0;
    end else if (wr_en) begin
      case (wr_index)
        nse_pkg::CFG_NAME_0_7:   name0_r <= wr_data;
        nse_pkg::CFG_NAME_8_15:  name1_r <= wr_data;
        nse_pkg::CFG_NAME_16_23: name2_r <= wr_data;
        nse_pkg::CFG_NAME_24_30: name3_r <= wr_data[55:0];
        default: ;
      endcase
    end
  end

  // Byte 0 of the name sits in the low bits.
  assign name = {name3_r, name2_r, name1_r, name0_r};

endmodule

>>> hdl/nse_scan.sv
// ----------------------------------------------------------------------------
// nse_scan
// Per-byte section parser: header capture, name compare, copy and skip.
// ----------------------------------------------------------------------------
module nse_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  logic [7:0]            in_byte,
  input  logic                  in_end,
  input  nse_pkg::name_t        name,
  output logic                  bnd_valid,
  output nse_pkg::bundle_t      bnd
);

  nse_pkg::phase_t                  phase_r, phase_nxt;
  logic [nse_pkg::HPOS_W-1:0]       hpos_r, hpos_nxt;
  logic [31:0]                      magic_r, magic_nxt;
  logic [31:0]                      size_r, size_nxt;
  logic                             name_eq_r, name_eq_nxt;
  logic                             name_end_r, name_end_nxt;
  logic [31:0]                      rem_r, rem_nxt;

  logic [nse_pkg::NAME_IDX_W-1:0]   name_idx;
  logic [7:0]                       wanted;
  logic [31:0]                      skip_len;
  logic                             finished;
  logic                             match;

  // Name byte under compare, and the skip length rounded up to 16.
  assign name_idx = nse_pkg::NAME_IDX_W'(hpos_r - nse_pkg::HPOS_W'(nse_pkg::NAME_FIELD_START));
  assign wanted   = name[name_idx];
  assign skip_len = (size_r + (nse_pkg::SKIP_ALIGN - 32'd1)) & ~(nse_pkg::SKIP_ALIGN - 32'd1);
  assign match    = (magic_r == nse_pkg::SECTION_MAGIC) && name_eq_r;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= nse_pkg::PH_HEADER;
      hpos_r     <= '0;
      magic_r    <= '0;
      size_r     <= '0;
      name_eq_r  <= 1'b1;
      name_end_r <= 1'b0;
      rem_r      <= '0;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      hpos_r     <= hpos_nxt;
      magic_r    <= magic_nxt;
      size_r     <= size_nxt;
      name_eq_r  <= name_eq_nxt;
      name_end_r <= name_end_nxt;
      rem_r      <= rem_nxt;
    end
  end

  // Next state and the results caused by the current byte.
  always_comb begin
    phase_nxt    = phase_r;
    hpos_nxt     = hpos_r;
    magic_nxt    = magic_r;
    size_nxt     = size_r;
    name_eq_nxt  = name_eq_r;
    name_end_nxt = name_end_r;
    rem_nxt      = rem_r;
    finished     = 1'b0;
    bnd_valid    = 1'b0;
    bnd.two      = 1'b0;
    bnd.res0     = nse_pkg::mk_result(nse_pkg::KIND_NOT_FOUND, 8'd0, 32'd0);
    bnd.res1     = nse_pkg::mk_result(nse_pkg::KIND_NOT_FOUND, 8'd0, 32'd0);

    case (phase_r)
      nse_pkg::PH_HEADER: begin
        // Capture magic and size little-endian, then compare the name.
        if (hpos_r < nse_pkg::HPOS_W'(4)) begin
          magic_nxt[{hpos_r[1:0], 3'b000} +: 8] = in_byte;
        end else if (hpos_r < nse_pkg::HPOS_W'(8)) begin
          size_nxt[{hpos_r[1:0], 3'b000} +: 8] = in_byte;
        end else if (hpos_r < nse_pkg::HPOS_W'(nse_pkg::NAME_FIELD_START +
                                                nse_pkg::NAME_COMPARE_BYTES)) begin
          if (name_eq_r && !name_end_r) begin
            if (in_byte != wanted) begin
              name_eq_nxt = 1'b0;
            end else if (in_byte == 8'd0) begin
              name_end_nxt = 1'b1;
            end
          end
        end

        if (hpos_r == nse_pkg::HPOS_W'(nse_pkg::HEADER_BYTES - 1)) begin
          if (match) begin
            if (size_r == 32'd0) begin
              bnd_valid = 1'b1;
              finished  = 1'b1;
              phase_nxt = nse_pkg::PH_DONE;
            end else begin
              rem_nxt   = size_r;
              phase_nxt = nse_pkg::PH_COPY;
            end
          end else begin
            rem_nxt = skip_len;
            if (skip_len == 32'd0) begin
              hpos_nxt     = '0;
              magic_nxt    = '0;
              size_nxt     = '0;
              name_eq_nxt  = 1'b1;
              name_end_nxt = 1'b0;
            end else begin
              phase_nxt = nse_pkg::PH_SKIP;
            end
          end
        end else begin
          hpos_nxt = hpos_r + nse_pkg::HPOS_W'(1);
        end
      end

      nse_pkg::PH_COPY: begin
        // Pass the byte on; the last one is followed by the size.
        bnd_valid = 1'b1;
        bnd.res0  = nse_pkg::mk_result(nse_pkg::KIND_BYTE, in_byte, 32'd0);
        rem_nxt   = rem_r - 32'd1;
        if (rem_r == 32'd1) begin
          bnd.two   = 1'b1;
          bnd.res1  = nse_pkg::mk_result(nse_pkg::KIND_FOUND, 8'd0, size_r);
          finished  = 1'b1;
          phase_nxt = nse_pkg::PH_DONE;
        end
      end

      nse_pkg::PH_SKIP: begin
        rem_nxt = rem_r - 32'd1;
        if (rem_r == 32'd1) begin
          phase_nxt    = nse_pkg::PH_HEADER;
          hpos_nxt     = '0;
          magic_nxt    = '0;
          size_nxt     = '0;
          name_eq_nxt  = 1'b1;
          name_end_nxt = 1'b0;
        end
      end

      default: ;
    endcase

    // End of image: report not found if still searching, then start afresh.
    if (in_end) begin
      if (phase_r != nse_pkg::PH_DONE && !finished) begin
        if (bnd_valid) begin
          bnd.two = 1'b1;
        end
        bnd_valid = 1'b1;
      end
      phase_nxt    = nse_pkg::PH_HEADER;
      hpos_nxt     = '0;
      magic_nxt    = '0;
      size_nxt     = '0;
      name_eq_nxt  = 1'b1;
      name_end_nxt = 1'b0;
      rem_nxt      = '0;
    end
  end

  // Two results come only from a copy byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && bnd_valid && bnd.two |-> phase_r == nse_pkg::PH_COPY)
    else $error("nse_scan: second result outside the copy phase");

  // Once the found result has been given, the rest of the image is silent.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == nse_pkg::PH_DONE |-> !bnd_valid)
    else $error("nse_scan: result after the search finished");

  // The image end always leaves a fresh header scan.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_end |=> phase_r == nse_pkg::PH_HEADER && hpos_r == '0 && rem_r == '0)
    else $error("nse_scan: state not restarted after image end");

  // The header position never runs past the header.
  assert property (@(posedge clk) disable iff (!rst_n)
    hpos_r <= nse_pkg::HPOS_W'(nse_pkg::HEADER_BYTES - 1))
    else $error("nse_scan: header position out of range");

endmodule

>>> hdl/nse_out_buf.sv
// ----------------------------------------------------------------------------
// nse_out_buf
// Two-entry result buffer; each entry holds the one or two results of a byte.
// ----------------------------------------------------------------------------
module nse_out_buf (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  nse_pkg::bundle_t                    wr_bnd,
  output logic                                full,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata: payload_byte [7:0], section_size [39:8]
  output logic [nse_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // out_tuser: result_kind [1:0]
  output logic [nse_pkg::OUT_TUSER_W-1:0]     out_tuser,
  output logic                                out_tlast
);

  nse_pkg::bundle_t  bnd_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              sub_r;

  nse_pkg::bundle_t  head;
  nse_pkg::result_t  cur;
  logic              last;
  logic              pop;

  // Current result: first or second of the head entry.
  assign head = bnd_r[rd_ptr_r];
  assign cur  = sub_r ? head.res1 : head.res0;
  assign last = sub_r || !head.two;

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {cur.size, cur.data_byte};
  assign out_tuser  = cur.kind;
  assign out_tlast  = last;
  assign full       = (cnt_r == 2'd2);

  assign pop     = out_tvalid && out_tready && last;
  assign cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, pop};

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bnd_r[wr_ptr_r] <= wr_bnd;
    end
  end

  // Pointers, fill count and the result select within an entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      sub_r    <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (out_tvalid && out_tready) begin
        sub_r <= !last;
      end
    end
  end

  // The fill count never exceeds the two entries.
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("nse_out_buf: fill count overflow");

  // The second result is selected only in a held two-result entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> cnt_r != 2'd0 && head.two)
    else $error("nse_out_buf: second result selected without one");

  // No write into a full buffer.
  assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en)
    else $error("nse_out_buf: write while full");

endmodule

>>> hdl/named_section_extractor.sv
// ----------------------------------------------------------------------------
// named_section_extractor
// Finds a named section in a firmware container image and streams it out.
// ----------------------------------------------------------------------------
// The block takes one image byte per cycle while in_tready is high, and each
// byte is parsed in the cycle it is accepted. Results leave through a
// two-entry buffer, one result a cycle while out_tready is high; most bytes
// give no result or one. The last payload byte of a match, and an image end
// during a copy, give two results, which the buffer absorbs. The input waits
// only while the buffer is full, which out_tready low or a two-result byte
// followed at once by a byte with a result can cause. cfg_ready is always high.
// A sequence ends with a found result carrying the size or a not-found result;
// later bytes up to the image end are dropped. Name registers are written by
// the user only while no image is in flight; the block does not enforce it.
module named_section_extractor (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: image_byte [7:0]
  input  logic [nse_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                 in_tlast,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata: payload_byte [7:0], section_size [39:8]
  output logic [nse_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser: result_kind [1:0]
  output logic [nse_pkg::OUT_TUSER_W-1:0]      out_tuser,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nse_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [nse_pkg::CFG_DATA_W-1:0]       cfg_data
);

  nse_pkg::name_t    name;
  nse_pkg::bundle_t  bnd;
  logic              bnd_valid;
  logic              in_fire;
  logic              buf_full;

  assign cfg_ready = 1'b1;
  assign in_tready = !buf_full;
  assign in_fire   = in_tvalid && in_tready;

  // Wanted name registers.
  nse_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .name     (name)
  );

  // Header parse, name compare, copy and skip.
  nse_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .in_end    (in_tlast),
    .name      (name),
    .bnd_valid (bnd_valid),
    .bnd       (bnd)
  );

  // Result buffer and output stream.
  nse_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (in_fire && bnd_valid),
    .wr_bnd     (bnd),
    .full       (buf_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
